### hdl/pbsr_pkg.sv
// Shared types and constants for the bank-switched RAM expansion.
// No dependencies; used by every module of the block.
package pbsr_pkg;

  localparam int PAGE_BITS_DEFAULT = 14;
  localparam int RAM_ADDR_W        = 18;

  localparam logic [7:0]  RESET_PORT_A    = 8'hdc;
  localparam logic [7:0]  RESET_PORT_B    = 8'hfe;
  localparam logic [5:0]  RESET_CONTROL   = 6'd4;
  localparam logic [15:0] DMA_ADDRESS     = 16'hff00;
  localparam int          CTRL_SELECT_BIT = 2;

  localparam logic [15:0] OFS_DATA_A = 16'd0;
  localparam logic [15:0] OFS_CTRL_A = 16'd1;
  localparam logic [15:0] OFS_DATA_B = 16'd2;
  localparam logic [15:0] OFS_CTRL_B = 16'd3;

  typedef enum logic [2:0] {
    MODE_REG_READ  = 3'd0,
    MODE_REG_WRITE = 3'd1,
    MODE_WIN_READ  = 3'd2,
    MODE_WIN_WRITE = 3'd3,
    MODE_SET_BANK  = 3'd4
  } mode_t;

  typedef struct packed {
    mode_t       mode;
    logic [15:0] address;
    logic [1:0]  window;
    logic [7:0]  data;
    logic [1:0]  video_bank;
  } item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [3:0] video_page;
    logic       video_changed;
  } reg_status_t;

endpackage

### hdl/pia_bank_switch_ram_expansion.sv
// Top level of the bank-switched RAM expansion: input register, logic, result register.
// Depends on pbsr_pkg, pbsr_regs and pbsr_translate.
//
// Each request is captured in an input register, decoded by one level of
// shallow logic against the register set, and then lands in a result
// register; a new request is taken every cycle while results drain. Register
// writes and the video bank take effect as the request moves into the result
// register, so the next request already sees them. The result register
// decouples the two sides: one request may wait in the input register while a
// result is stalled.
module pia_bank_switch_ram_expansion #(
  parameter int PAGE_BITS = pbsr_pkg::PAGE_BITS_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [2:0]                       mode,
  input  logic [15:0]                      address,
  input  logic [1:0]                       window,
  input  logic [7:0]                       data,
  input  logic [1:0]                       video_bank,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [7:0]                       read_data,
  output logic [pbsr_pkg::RAM_ADDR_W-1:0]  ram_address,
  output logic                             ram_write,
  output logic [3:0]                       video_page,
  output logic                             video_changed,
  output logic                             dma_trigger
);
  import pbsr_pkg::*;

  item_t                 s1_item;
  logic                  s1_valid;
  logic                  advance;
  logic [15:0]           pages;
  reg_status_t           status;
  logic [RAM_ADDR_W-1:0] ram_address_next;
  logic                  ram_write_next;
  logic                  dma_trigger_next;

  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  // hold the request until it moves on
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_item.mode       <= mode_t'(mode);
      s1_item.address    <= address;
      s1_item.window     <= window;
      s1_item.data       <= data;
      s1_item.video_bank <= video_bank;
    end
  end

  pbsr_regs u_regs (
    .clk    (clk),
    .rst    (rst),
    .item   (s1_item),
    .commit (advance),
    .pages  (pages),
    .status (status)
  );

  pbsr_translate #(
    .PAGE_BITS (PAGE_BITS)
  ) u_translate (
    .item        (s1_item),
    .pages       (pages),
    .ram_address (ram_address_next),
    .ram_write   (ram_write_next),
    .dma_trigger (dma_trigger_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      read_data     <= status.read_data;
      ram_address   <= ram_address_next;
      ram_write     <= ram_write_next;
      video_page    <= status.video_page;
      video_changed <= status.video_changed;
      dma_trigger   <= dma_trigger_next;
    end
  end

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (s1_valid && out_valid && !out_ready))
    else $error("input stalled without a blocked result");

  a_dma_is_write: assert property (@(posedge clk) disable iff (rst)
    (out_valid && dma_trigger) |-> ram_write)
    else $error("dma trigger without a window write");

  a_read_excl: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (read_data != 8'd0)) |-> (!ram_write && !video_changed))
    else $error("register read data alongside another effect");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> (!out_valid && !s1_valid))
    else $error("pipeline not empty after reset");

endmodule

### hdl/pbsr_regs.sv
// Port, direction and control registers with the held video bank.
// Depends on pbsr_pkg for item and status types and register offsets.
module pbsr_regs (
  input  logic                 clk,
  input  logic                 rst,
  input  pbsr_pkg::item_t      item,
  input  logic                 commit,
  output logic [15:0]          pages,
  output pbsr_pkg::reg_status_t status
);
  import pbsr_pkg::*;

  logic [7:0] port_a, port_a_next;
  logic [7:0] port_b, port_b_next;
  logic [7:0] direction_a, direction_a_next;
  logic [7:0] direction_b, direction_b_next;
  logic [5:0] control_a, control_a_next;
  logic [5:0] control_b, control_b_next;
  logic [1:0] video_bank_held, video_bank_held_next;
  logic [7:0] read_value;
  logic       changed;

  always_comb begin
    port_a_next          = port_a;
    port_b_next          = port_b;
    direction_a_next     = direction_a;
    direction_b_next     = direction_b;
    control_a_next       = control_a;
    control_b_next       = control_b;
    video_bank_held_next = video_bank_held;
    read_value           = 8'd0;
    changed              = 1'b0;
    case (item.mode)
      MODE_REG_READ: begin
        case (item.address)
          OFS_DATA_A: read_value = control_a[CTRL_SELECT_BIT] ? port_a : direction_a;
          OFS_CTRL_A: read_value = {2'b00, control_a};
          OFS_DATA_B: read_value = control_b[CTRL_SELECT_BIT] ? port_b : direction_b;
          OFS_CTRL_B: read_value = {2'b00, control_b};
          default:    read_value = 8'd0;
        endcase
      end
      MODE_REG_WRITE: begin
        case (item.address)
          OFS_DATA_A: begin
            if (control_a[CTRL_SELECT_BIT]) port_a_next = item.data;
            else direction_a_next = item.data;
          end
          OFS_CTRL_A: control_a_next = item.data[5:0];
          OFS_DATA_B: begin
            if (control_b[CTRL_SELECT_BIT]) begin
              port_b_next = item.data;
              changed     = (port_b[7:6] != item.data[7:6]);
            end else begin
              direction_b_next = item.data;
            end
          end
          OFS_CTRL_B: control_b_next = item.data[5:0];
          default: ;
        endcase
      end
      MODE_SET_BANK: begin
        video_bank_held_next = item.video_bank;
        changed              = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      port_a          <= RESET_PORT_A;
      port_b          <= RESET_PORT_B;
      direction_a     <= 8'd0;
      direction_b     <= 8'd0;
      control_a       <= RESET_CONTROL;
      control_b       <= RESET_CONTROL;
      video_bank_held <= 2'd0;
    end else if (commit) begin
      port_a          <= port_a_next;
      port_b          <= port_b_next;
      direction_a     <= direction_a_next;
      direction_b     <= direction_b_next;
      control_a       <= control_a_next;
      control_b       <= control_b_next;
      video_bank_held <= video_bank_held_next;
    end
  end

  assign pages                = {port_b, port_a};
  assign status.read_data     = read_value;
  assign status.video_page    = {port_b_next[7:6], video_bank_held_next};
  assign status.video_changed = changed;

endmodule

### hdl/pbsr_translate.sv
// Window-to-RAM address translation and DMA trigger decode.
// Depends on pbsr_pkg for the item type, modes and address constants.
module pbsr_translate #(
  parameter int PAGE_BITS = pbsr_pkg::PAGE_BITS_DEFAULT
) (
  input  pbsr_pkg::item_t                  item,
  input  logic [15:0]                      pages,
  output logic [pbsr_pkg::RAM_ADDR_W-1:0]  ram_address,
  output logic                             ram_write,
  output logic                             dma_trigger
);
  import pbsr_pkg::*;

  localparam int FULL_W = 4 + PAGE_BITS;

  logic [3:0]        page;
  logic [FULL_W-1:0] full_address;
  logic              window_access;

  assign page          = pages[{item.window, 2'b00} +: 4];
  assign full_address  = {page, item.address[PAGE_BITS-1:0]};
  assign window_access = (item.mode == MODE_WIN_READ) || (item.mode == MODE_WIN_WRITE);
  assign ram_address   = window_access ? RAM_ADDR_W'(full_address) : '0;
  assign ram_write     = (item.mode == MODE_WIN_WRITE);
  assign dma_trigger   = ram_write && (item.address == DMA_ADDRESS);

endmodule
